// ----- src/http_response_header_check_top_defines.svh -----
// ----------------------------------------------------------------------------
// HTTP response header check assertion macros
// Shared macros for the concurrent checks of the response header checker.
// ----------------------------------------------------------------------------
`ifndef HTTP_RESPONSE_HEADER_CHECK_TOP_DEFINES_SVH
`define HTTP_RESPONSE_HEADER_CHECK_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled during reset.
`define HRHC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and disabled during reset.
`define HRHC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/hrhc_pkg.sv -----
// ----------------------------------------------------------------------------
// HTTP response header check package
// Beat types, error codes, length limits and the version tag table.
// ----------------------------------------------------------------------------
`default_nettype none

package hrhc_pkg;

  localparam int unsigned MaxLen  = 65535;
  localparam int unsigned CntW    = $clog2(MaxLen + 2);
  localparam int unsigned PrefixLen = 4;
  localparam int unsigned BodyMin   = 15;
  localparam int unsigned TagLen    = 5;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_SHORT      = 3'd1;
  localparam logic [2:0] ERR_PREFIX     = 3'd2;
  localparam logic [2:0] ERR_BODY_SHORT = 3'd3;
  localparam logic [2:0] ERR_NOT_HTTP   = 3'd4;
  localparam logic [2:0] ERR_STATUS     = 3'd5;
  localparam logic [2:0] ERR_NO_TERM    = 3'd6;
  localparam logic [2:0] ERR_TOO_LONG   = 3'd7;

  localparam logic CFG_SUCCESS_CODE = 1'b0;
  localparam logic CFG_FAILURE_CODE = 1'b1;

  localparam logic [7:0] CHR_CR    = 8'h0d;
  localparam logic [7:0] CHR_LF    = 8'h0a;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_PLUS  = 8'h2b;
  localparam logic [7:0] CHR_MINUS = 8'h2d;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_TAB   = 8'h09;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic              accepted;
    logic [2:0]        error_kind;
    logic signed [31:0] status_code;
    logic [15:0]       content_start;
    logic [15:0]       content_length;
  } out_beat_t;

  typedef enum logic [4:0] {
    PH_VERSION = 5'b00001,
    PH_GAP     = 5'b00010,
    PH_LEAD    = 5'b00100,
    PH_DIGITS  = 5'b01000,
    PH_DONE    = 5'b10000
  } phase_t;

  function automatic logic [7:0] http_tag(input logic [2:0] idx);
    logic [7:0] chr;
    case (idx)
      3'd0:    chr = 8'h48;
      3'd1:    chr = 8'h54;
      3'd2:    chr = 8'h54;
      3'd3:    chr = 8'h50;
      3'd4:    chr = 8'h2f;
      default: chr = 8'h00;
    endcase
    return chr;
  endfunction

endpackage

`default_nettype wire

// ----- src/hrhc_core.sv -----
// ----------------------------------------------------------------------------
// HTTP response header check core
// Per-byte matchers and status accumulator, plus the verdict for the last beat.
// ----------------------------------------------------------------------------
`default_nettype none

module hrhc_core import hrhc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire in_beat_t    beat,
  input  wire logic [31:0] success_code,
  input  wire logic [31:0] failure_code,
  output out_beat_t        verdict
);

  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [31:0]     prefix_r, prefix_nxt;
  phase_t          phase_r, phase_nxt;
  logic            magic_r, magic_nxt;
  logic [31:0]     acc_r, acc_nxt;
  logic            neg_r, neg_nxt;
  logic [1:0]      term_r, term_nxt;
  logic            seen_r, seen_nxt;
  logic [15:0]     start_r, start_nxt;

  logic [7:0]      b;
  logic [CntW-1:0] pos;
  logic            in_range;
  logic            is_digit;
  logic            is_lead_sp;
  logic [31:0]     acc_step;
  logic [31:0]     status;

  assign b          = beat.data_byte;
  assign pos        = cnt_r - CntW'(PrefixLen);
  assign in_range   = (cnt_r <= CntW'(MaxLen));
  assign is_digit   = (b >= CHR_ZERO) && (b <= CHR_NINE);
  assign is_lead_sp = (b >= CHR_TAB) && (b <= CHR_CR);
  assign acc_step   = {acc_r[28:0], 3'b000} + {acc_r[30:0], 1'b0} + {28'd0, b[3:0]};

  always_comb begin
    cnt_nxt    = cnt_r;
    prefix_nxt = prefix_r;
    phase_nxt  = phase_r;
    magic_nxt  = magic_r;
    acc_nxt    = acc_r;
    neg_nxt    = neg_r;
    term_nxt   = term_r;
    seen_nxt   = seen_r;
    start_nxt  = start_r;
    if (in_range) begin
      cnt_nxt = cnt_r + CntW'(1);
      if (cnt_r < CntW'(PrefixLen)) begin
        prefix_nxt[cnt_r[1:0]*8 +: 8] = prefix_r[cnt_r[1:0]*8 +: 8] | b;
      end else begin
        case (phase_r)
          PH_VERSION: begin
            if ((pos < CntW'(TagLen)) && (b != http_tag(pos[2:0]))) begin
              magic_nxt = 1'b0;
            end
            if (b == CHR_SPACE) begin
              phase_nxt = PH_GAP;
            end
          end
          PH_GAP, PH_LEAD: begin
            if (b == CHR_SPACE) begin
              if (phase_r == PH_LEAD) begin
                phase_nxt = PH_DONE;
              end
            end else if (is_lead_sp) begin
              phase_nxt = PH_LEAD;
            end else if (b == CHR_PLUS) begin
              phase_nxt = PH_DIGITS;
            end else if (b == CHR_MINUS) begin
              neg_nxt   = 1'b1;
              phase_nxt = PH_DIGITS;
            end else if (is_digit) begin
              acc_nxt   = acc_step;
              phase_nxt = PH_DIGITS;
            end else begin
              phase_nxt = PH_DONE;
            end
          end
          PH_DIGITS: begin
            if (is_digit) begin
              acc_nxt = acc_step;
            end else begin
              phase_nxt = PH_DONE;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
        if (!seen_r) begin
          if (b == CHR_CR) begin
            term_nxt = (term_r == 2'd2) ? 2'd3 : 2'd1;
          end else if ((b == CHR_LF) && (term_r == 2'd1)) begin
            term_nxt = 2'd2;
          end else if ((b == CHR_LF) && (term_r == 2'd3)) begin
            seen_nxt  = 1'b1;
            start_nxt = 16'(pos + CntW'(1));
            term_nxt  = 2'd0;
          end else begin
            term_nxt = 2'd0;
          end
        end
      end
    end
  end

  assign status = neg_nxt ? (32'd0 - acc_nxt) : acc_nxt;

  always_comb begin
    verdict.content_start  = 16'd0;
    verdict.content_length = 16'd0;
    if (cnt_nxt > CntW'(MaxLen)) begin
      verdict.error_kind  = ERR_TOO_LONG;
      verdict.status_code = failure_code;
    end else if (cnt_nxt < CntW'(PrefixLen)) begin
      verdict.error_kind  = ERR_SHORT;
      verdict.status_code = failure_code;
    end else if (prefix_nxt != success_code) begin
      verdict.error_kind  = ERR_PREFIX;
      verdict.status_code = prefix_nxt;
    end else if (cnt_nxt < CntW'(PrefixLen + BodyMin)) begin
      verdict.error_kind  = ERR_BODY_SHORT;
      verdict.status_code = prefix_nxt;
    end else if (!magic_nxt) begin
      verdict.error_kind  = ERR_NOT_HTTP;
      verdict.status_code = prefix_nxt;
    end else if (status != success_code) begin
      verdict.error_kind  = ERR_STATUS;
      verdict.status_code = status;
    end else if (!seen_nxt) begin
      verdict.error_kind  = ERR_NO_TERM;
      verdict.status_code = status;
    end else begin
      verdict.error_kind     = ERR_NONE;
      verdict.status_code    = status;
      verdict.content_start  = start_nxt;
      verdict.content_length = 16'(cnt_nxt - CntW'(PrefixLen)) - start_nxt;
    end
    verdict.accepted = (verdict.error_kind == ERR_NONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && beat.last_byte)) begin
      cnt_r    <= '0;
      prefix_r <= '0;
      phase_r  <= PH_VERSION;
      magic_r  <= 1'b1;
      acc_r    <= '0;
      neg_r    <= 1'b0;
      term_r   <= 2'd0;
      seen_r   <= 1'b0;
      start_r  <= '0;
    end else if (step) begin
      cnt_r    <= cnt_nxt;
      prefix_r <= prefix_nxt;
      phase_r  <= phase_nxt;
      magic_r  <= magic_nxt;
      acc_r    <= acc_nxt;
      neg_r    <= neg_nxt;
      term_r   <= term_nxt;
      seen_r   <= seen_nxt;
      start_r  <= start_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/http_response_header_check_top.sv -----
// The verdict is registered and valid in the cycle after the beat marked last is accepted.
// Throughput: one byte per cycle while in_ready is high; the per-byte matchers and
// accumulator update in the cycle a beat is taken, and the output register frees
// the input side. Input ready drops only while a verdict waits and the sink is not ready.
// Reset is synchronous and active low; the success and failure code registers return to 200 and -1.
// ----------------------------------------------------------------------------
// HTTP response header check top level
// Byte-stream checker for a code prefix, status line and header terminator.
// ----------------------------------------------------------------------------
`default_nettype none

`include "http_response_header_check_top_defines.svh"

module http_response_header_check_top import hrhc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_beat_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_beat_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  logic [31:0] success_r;
  logic [31:0] failure_r;
  logic        out_vld_r;
  out_beat_t   out_r;
  out_beat_t   verdict;
  logic        step;

  assign in_ready  = !out_vld_r || out_ready;
  assign step      = in_valid && in_ready;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  hrhc_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .beat         (in_data),
    .success_code (success_r),
    .failure_code (failure_r),
    .verdict      (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      success_r <= 32'd200;
      failure_r <= 32'hffff_ffff;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SUCCESS_CODE: success_r <= cfg_wdata;
        CFG_FAILURE_CODE: failure_r <= cfg_wdata;
        default:          success_r <= success_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step && in_data.last_byte) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_data.last_byte) begin
      out_r <= verdict;
    end
  end

  `HRHC_ASSERT_NOW(a_accept_matches_kind, out_vld_r,
    out_r.accepted == (out_r.error_kind == ERR_NONE),
    "accepted flag disagrees with error kind")

  `HRHC_ASSERT_NOW(a_offsets_zero_on_error, out_vld_r && !out_r.accepted,
    (out_r.content_start == 16'd0) && (out_r.content_length == 16'd0),
    "content offsets nonzero on a rejected response")

  `HRHC_ASSERT_NEXT(a_last_gives_verdict, step && in_data.last_byte,
    out_vld_r,
    "no verdict after the last beat")

endmodule

`default_nettype wire
